/* rtl/mpld_pkg.sv */
// Shared types, constants and address helpers for the page framebuffer line drawer.
package mpld_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PIXEL = 3'd1,
    OP_LINE  = 3'd2,
    OP_RECT  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    JOB_CLEAR = 2'd0,
    JOB_LINE  = 2'd1,
    JOB_READ  = 2'd2
  } job_e;

  typedef struct packed {
    job_e       kind;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic       ink;
    logic [2:0] page;
    logic [6:0] column;
  } job_t;

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [7:0] page,
                                                  input logic [7:0] col);
    logic [15:0] a;
    a = 16'(page) * 16'(PANEL_WIDTH) + 16'(col);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic on_panel(input logic [7:0] x, input logic [7:0] y);
    return ({1'b0, x} < 9'(PANEL_WIDTH)) && ({1'b0, y} < 9'(PANEL_HEIGHT));
  endfunction

endpackage

/* rtl/mono_page_framebuffer_line_drawer.sv */
// Top level of the page framebuffer line drawer: front end, job queue, drawing engine.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         start && !busy                operation_i .. read_column_i
//   result    out        result_strobe_o, one cycle    page_byte_o
//
// An on-panel pixel is a read-modify-write of one byte in the frame RAM (B_LN_RD, B_LN_WR);
// an off-panel pixel is only stepped past in B_LN_RD. A read's byte passes through the RAM's
// registered read and the output register. A clear sweeps one byte a cycle over all
// STORE_BYTES (1024); after reset the same sweep zeroes the RAM, with busy high until it
// ends. A request waits in the front end, as four line jobs for a rectangle, while the
// two-entry queue is full; results cannot be held off by the receiver.
module mono_page_framebuffer_line_drawer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] operation_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_far_i,
  input  logic [7:0] y_far_i,
  input  logic       ink_i,
  input  logic [2:0] read_page_i,
  input  logic [6:0] read_column_i,
  output logic       result_strobe_o,
  output logic [7:0] page_byte_o
);
  import mpld_pkg::*;

  logic init_busy, full, empty, push, pop;
  job_t push_job, head_job;

  mpld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_far_i      (x_far_i),
    .y_far_i      (y_far_i),
    .ink_i        (ink_i),
    .read_page_i  (read_page_i),
    .read_column_i(read_column_i),
    .init_busy_i  (init_busy),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  mpld_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (full),
    .pop_i  (pop),
    .job_o  (head_job),
    .empty_o(empty)
  );

  mpld_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .result_strobe_o(result_strobe_o),
    .page_byte_o    (page_byte_o)
  );

endmodule

/* rtl/mpld_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mpld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/mpld_front.sv */
// Front end: takes requests, drops unknown codes, splits rectangles into four lines.
module mpld_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      operation_i,
  input  logic [7:0]      x_start_i,
  input  logic [7:0]      y_start_i,
  input  logic [7:0]      x_far_i,
  input  logic [7:0]      y_far_i,
  input  logic            ink_i,
  input  logic [2:0]      read_page_i,
  input  logic [6:0]      read_column_i,
  input  logic            init_busy_i,
  input  logic            full_i,
  output logic            push_o,
  output mpld_pkg::job_t  job_o
);
  import mpld_pkg::*;

  logic       pend_q, pend_d;
  logic [1:0] part_q, part_d;
  op_e        op_q;
  logic [7:0] xs_q, ys_q, xf_q, yf_q;
  logic       ink_q;
  logic [2:0] page_q;
  logic [6:0] col_q;
  logic       accept, known, last;
  logic [7:0] xe, ye;

  assign busy   = pend_q | init_busy_i;
  assign accept = start & ~busy;
  assign known  = operation_i inside {OP_CLEAR, OP_PIXEL, OP_LINE, OP_RECT, OP_READ};
  assign push_o = pend_q & ~full_i;
  assign xe     = xs_q + xf_q;
  assign ye     = ys_q + yf_q;
  assign last   = (op_q != OP_RECT) || (part_q == 2'd3);

  always_comb begin
    job_o        = '0;
    job_o.ink    = ink_q;
    job_o.page   = page_q;
    job_o.column = col_q;
    case (op_q)
      OP_CLEAR: begin
        job_o.kind = JOB_CLEAR;
      end
      OP_PIXEL: begin
        job_o.kind = JOB_LINE;
        job_o.x0   = xs_q;
        job_o.y0   = ys_q;
        job_o.x1   = xs_q;
        job_o.y1   = ys_q;
      end
      OP_LINE: begin
        job_o.kind = JOB_LINE;
        job_o.x0   = xs_q;
        job_o.y0   = ys_q;
        job_o.x1   = xf_q;
        job_o.y1   = yf_q;
      end
      OP_RECT: begin
        job_o.kind = JOB_LINE;
        case (part_q)
          2'd0: begin
            job_o.x0 = xs_q; job_o.y0 = ys_q; job_o.x1 = xe;   job_o.y1 = ys_q;
          end
          2'd1: begin
            job_o.x0 = xs_q; job_o.y0 = ye;   job_o.x1 = xe;   job_o.y1 = ye;
          end
          2'd2: begin
            job_o.x0 = xs_q; job_o.y0 = ys_q; job_o.x1 = xs_q; job_o.y1 = ye;
          end
          default: begin
            job_o.x0 = xe;   job_o.y0 = ys_q; job_o.x1 = xe;   job_o.y1 = ye;
          end
        endcase
      end
      default: begin
        job_o.kind = JOB_READ;
      end
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    if (accept && known) begin
      pend_d = 1'b1;
      part_d = 2'd0;
    end else if (push_o) begin
      if (last) begin
        pend_d = 1'b0;
      end else begin
        part_d = part_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      part_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(operation_i);
      xs_q   <= x_start_i;
      ys_q   <= y_start_i;
      xf_q   <= x_far_i;
      yf_q   <= y_far_i;
      ink_q  <= ink_i;
      page_q <= read_page_i;
      col_q  <= read_column_i;
    end
  end

endmodule

/* rtl/mpld_queue.sv */
// Short job queue between the front end and the drawing engine.
module mpld_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpld_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output mpld_pkg::job_t job_o,
  output logic           empty_o
);
  import mpld_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/mpld_back.sv */
// Drawing engine: clear sweep, Bresenham walk with byte read-modify-write, byte read.
module mpld_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mpld_pkg::job_t job_i,
  output logic           pop_o,
  output logic           init_busy_o,
  output logic           result_strobe_o,
  output logic [7:0]     page_byte_o
);
  import mpld_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE    = 5'b00001,
    B_SWEEP   = 5'b00010,
    B_LN_RD   = 5'b00100,
    B_LN_WR   = 5'b01000,
    B_RD_DONE = 5'b10000
  } back_state_e;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  back_state_e       state_q, state_d;
  logic              init_q, init_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [7:0]        fill_q, fill_d;
  logic [7:0]        cx_q, cx_d, cy_q, cy_d, ex_q, ex_d, ey_q, ey_d;
  logic [7:0]        dx_q, dx_d, dy_q, dy_d;
  logic              sxn_q, sxn_d, syn_q, syn_d;
  logic signed [9:0] err_q, err_d;
  logic              ink_q, ink_d;
  logic              rok_q, rok_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              oval_q, oval_d;
  logic [7:0]        obyte_q, obyte_d;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata, mask;
  logic [8:0]        dxs, dys, ndxs, ndys;
  logic [7:0]        dx_n, dy_n;
  logic signed [10:0] e2;
  logic              go_x, go_y, at_end;
  logic signed [9:0] err_nxt;
  logic [7:0]        cx_nxt, cy_nxt;

  mpld_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign init_busy_o     = init_q;
  assign result_strobe_o = oval_q;
  assign page_byte_o     = obyte_q;

  assign dxs  = {1'b0, job_i.x1} - {1'b0, job_i.x0};
  assign dys  = {1'b0, job_i.y1} - {1'b0, job_i.y0};
  assign ndxs = -dxs;
  assign ndys = -dys;
  assign dx_n = dxs[8] ? ndxs[7:0] : dxs[7:0];
  assign dy_n = dys[8] ? ndys[7:0] : dys[7:0];

  assign e2      = $signed({err_q, 1'b0});
  assign go_x    = e2 > -$signed({3'b000, dy_q});
  assign go_y    = e2 < $signed({3'b000, dx_q});
  assign err_nxt = err_q - (go_x ? $signed({2'b00, dy_q}) : 10'sd0)
                         + (go_y ? $signed({2'b00, dx_q}) : 10'sd0);
  assign cx_nxt  = go_x ? (sxn_q ? cx_q - 8'd1 : cx_q + 8'd1) : cx_q;
  assign cy_nxt  = go_y ? (syn_q ? cy_q - 8'd1 : cy_q + 8'd1) : cy_q;
  assign at_end  = (cx_q == ex_q) && (cy_q == ey_q);
  assign mask    = 8'd1 << cy_q[2:0];

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    sweep_d = sweep_q;
    fill_d  = fill_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    sxn_d   = sxn_q;
    syn_d   = syn_q;
    err_d   = err_q;
    ink_d   = ink_q;
    rok_d   = rok_q;
    addr_d  = addr_q;
    oval_d  = 1'b0;
    obyte_d = obyte_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = ink_q ? (rdata | mask) : (rdata & ~mask);
    raddr   = byte_addr({5'd0, job_i.page}, {1'b0, job_i.column});
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (job_i.kind)
            JOB_CLEAR: begin
              fill_d  = job_i.ink ? FILL_ONES : FILL_ZEROS;
              sweep_d = '0;
              state_d = B_SWEEP;
            end
            JOB_LINE: begin
              cx_d    = job_i.x0;
              cy_d    = job_i.y0;
              ex_d    = job_i.x1;
              ey_d    = job_i.y1;
              dx_d    = dx_n;
              dy_d    = dy_n;
              sxn_d   = dxs[8];
              syn_d   = dys[8];
              err_d   = $signed({2'b00, dx_n}) - $signed({2'b00, dy_n});
              ink_d   = job_i.ink;
              state_d = B_LN_RD;
            end
            default: begin
              rok_d   = (9'(job_i.page) < 9'(PAGE_COUNT))
                     && (9'(job_i.column) < 9'(PANEL_WIDTH));
              state_d = B_RD_DONE;
            end
          endcase
        end
      end
      B_SWEEP: begin
        we      = 1'b1;
        waddr   = sweep_q;
        wdata   = fill_q;
        sweep_d = sweep_q + ADDR_W'(1);
        if (sweep_q == LAST_ADDR) begin
          init_d  = 1'b0;
          state_d = B_IDLE;
        end
      end
      B_LN_RD: begin
        raddr = byte_addr({3'd0, cy_q[7:3]}, cx_q);
        if (on_panel(cx_q, cy_q)) begin
          addr_d  = raddr;
          state_d = B_LN_WR;
        end else if (at_end) begin
          state_d = B_IDLE;
        end else begin
          err_d = err_nxt;
          cx_d  = cx_nxt;
          cy_d  = cy_nxt;
        end
      end
      B_LN_WR: begin
        we = 1'b1;
        if (at_end) begin
          state_d = B_IDLE;
        end else begin
          err_d   = err_nxt;
          cx_d    = cx_nxt;
          cy_d    = cy_nxt;
          state_d = B_LN_RD;
        end
      end
      B_RD_DONE: begin
        oval_d  = 1'b1;
        obyte_d = rok_q ? rdata : FILL_ZEROS;
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_SWEEP;
      init_q  <= 1'b1;
      sweep_q <= '0;
      fill_q  <= FILL_ZEROS;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      sweep_q <= sweep_d;
      fill_q  <= fill_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sxn_q   <= sxn_d;
    syn_q   <= syn_d;
    err_q   <= err_d;
    ink_q   <= ink_d;
    rok_q   <= rok_d;
    addr_q  <= addr_d;
    obyte_q <= obyte_d;
  end

endmodule

/* rtl/mpld_checker.sv */
// Port-level checks for the page framebuffer line drawer, bound to the top level.
module mpld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] operation_i,
  input logic       result_strobe_o
);
  import mpld_pkg::*;

  logic       rd_acc;
  logic [2:0] open_q;

  assign rd_acc = start && !busy && (operation_i == OP_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 3'd0;
    end else begin
      open_q <= open_q + 3'(rd_acc) - 3'(result_strobe_o);
    end
  end

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobes in adjacent cycles");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i <= OP_READ)) |=> busy)
    else $error("request taken without going busy");

  a_strobe_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (open_q != 3'd0))
    else $error("result without an outstanding read");

  a_busy_out_of_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy)
    else $error("not busy while the frame RAM is being cleared");

endmodule

bind mono_page_framebuffer_line_drawer mpld_checker u_mpld_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .result_strobe_o(result_strobe_o)
);
